[hdl/modbus_rtu_read_registers_master_top_defines.svh]
// Assertion macros for the Modbus RTU read-registers master.
`ifndef MODBUS_RTU_READ_REGISTERS_MASTER_TOP_DEFINES_SVH
`define MODBUS_RTU_READ_REGISTERS_MASTER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset
`define MBRM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define MBRM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/mbrm_pkg.sv]
// Shared types, codes and the CRC-16 step for the Modbus RTU read-registers master.
`default_nettype none
package mbrm_pkg;

  // input operations
  localparam logic [1:0] OP_START   = 2'd0;
  localparam logic [1:0] OP_RX      = 2'd1;
  localparam logic [1:0] OP_TIMEOUT = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_REQ  = 2'd0;
  localparam logic [1:0] KIND_REG  = 2'd1;
  localparam logic [1:0] KIND_FAIL = 2'd2;

  // failure status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_EXCEPTION  = 3'd1;
  localparam logic [2:0] ST_NO_RESP    = 3'd2;
  localparam logic [2:0] ST_INCOMPLETE = 3'd3;
  localparam logic [2:0] ST_BAD_HEADER = 3'd4;
  localparam logic [2:0] ST_CRC_ERROR  = 3'd5;

  // configuration register indexes
  localparam logic [1:0] CFG_SLAVE_ADDR = 2'd0;
  localparam logic [1:0] CFG_START_REG  = 2'd1;
  localparam logic [1:0] CFG_REG_COUNT  = 2'd2;

  // protocol constants
  localparam logic [7:0]  FUNC_READ_HOLD = 8'h03;
  localparam logic [7:0]  FUNC_EXCEPTION = 8'h83;
  localparam logic [15:0] CRC_INIT       = 16'hFFFF;
  localparam logic [15:0] CRC_POLY       = 16'hA001;
  localparam logic [2:0]  REQ_LAST_IDX   = 3'd7;
  localparam logic [2:0]  REQ_CRC_LO_IDX = 3'd6;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] value;
    logic [5:0]  index;
    logic [2:0]  status;
    logic [7:0]  exception_code;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  slave_address;
    logic [15:0] start_register;
    logic [2:0]  register_count;
  } cfg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_REQ,
    S_FAIL,
    S_RDREQ,
    S_REGS
  } state_t;

  // one byte folded into a reflected CRC-16
  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

[hdl/modbus_rtu_read_registers_master_top.sv]
// Top level of the Modbus RTU read-holding-registers master.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------
//  in_     | input     | in_valid/in_stall  | in_data: operation, rx_byte
//  out_    | output    | out_valid/out_stall| out_data: kind..last
//  cfg_    | input     | cfg_we             | cfg_index, cfg_data
//
// An item is latched, then executed; the next is taken only back in idle.
// A start streams 8 request bytes, one per cycle while the output is not
// stalled; the request CRC is folded one byte per cycle as bytes go out.
// Register results are each read from the store memory, then emitted.
// Reset is synchronous; the store needs no clearing pass. A stalled output
// holds its item and pauses the sequencer; in_stall holds off a new input.
`default_nettype none
`include "modbus_rtu_read_registers_master_top_defines.svh"
module modbus_rtu_read_registers_master_top #(
  parameter int MAX_REGS = 4
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire mbrm_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output mbrm_pkg::out_item_t      out_data,
  input  wire logic                cfg_we,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [15:0]         cfg_data
);

  localparam int AW    = (MAX_REGS > 1) ? $clog2(MAX_REGS) : 1;
  localparam int CNT_W = $clog2(5 + 2 * MAX_REGS + 1);

  mbrm_pkg::cfg_t cfg_r, cfg_nxt;

  logic          mem_wr_en;
  logic [AW-1:0] mem_wr_addr;
  logic [15:0]   mem_wr_data;
  logic          mem_rd_en;
  logic [AW-1:0] mem_rd_addr;
  logic [15:0]   mem_rd_data;

  // configuration register decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        mbrm_pkg::CFG_SLAVE_ADDR: cfg_nxt.slave_address  = cfg_data[7:0];
        mbrm_pkg::CFG_START_REG:  cfg_nxt.start_register = cfg_data;
        mbrm_pkg::CFG_REG_COUNT:  cfg_nxt.register_count = cfg_data[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.slave_address  <= 8'd1;
      cfg_r.start_register <= 16'd0;
      cfg_r.register_count <= 3'd4;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  mbrm_ctrl #(
    .MAX_REGS (MAX_REGS),
    .AW       (AW),
    .CNT_W    (CNT_W)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data)
  );

  mbrm_store #(
    .DEPTH (MAX_REGS),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // an accepted request is worked on before the next one is taken
  `MBRM_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "input taken while busy")
  // a failure report is always the single, final result of its request
  `MBRM_ASSERT_NOW(a_fail_last, out_valid && out_data.kind == mbrm_pkg::KIND_FAIL, out_data.last && out_data.value == 16'h0000, "failure report malformed")
  // register values carry an ok status and no exception code
  `MBRM_ASSERT_NOW(a_reg_ok, out_valid && out_data.kind == mbrm_pkg::KIND_REG, out_data.status == mbrm_pkg::ST_OK && out_data.exception_code == 8'h00, "register result with failure fields")

endmodule
`default_nettype wire

[hdl/mbrm_store.sv]
// Register store: single-port-write, registered-read memory of received register values.
`default_nettype none
module mbrm_store #(
  parameter int DEPTH = 4,
  parameter int AW    = 2
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [15:0]   wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [15:0]   rd_data
);

  logic [15:0] mem [DEPTH];
  logic [15:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered, holds between reads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

[hdl/mbrm_ctrl.sv]
// Transaction sequencer: request builder, frame receiver and result output register.
`default_nettype none
module mbrm_ctrl #(
  parameter int MAX_REGS = 4,
  parameter int AW       = 2,
  parameter int CNT_W    = 4
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire mbrm_pkg::cfg_t     cfg,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire mbrm_pkg::in_item_t in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output mbrm_pkg::out_item_t     out_data,
  output logic                    mem_wr_en,
  output logic [AW-1:0]           mem_wr_addr,
  output logic [15:0]             mem_wr_data,
  output logic                    mem_rd_en,
  output logic [AW-1:0]           mem_rd_addr,
  input  wire logic [15:0]        mem_rd_data
);

  mbrm_pkg::state_t    state_r, state_nxt;
  mbrm_pkg::in_item_t  item_r, item_nxt;
  mbrm_pkg::out_item_t out_data_r, out_data_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [15:0]         crc_r, crc_nxt;
  logic [15:0]         txcrc_r, txcrc_nxt;
  logic [7:0]          faddr_r, faddr_nxt;
  logic [7:0]          ffunc_r, ffunc_nxt;
  logic [7:0]          flen_r, flen_nxt;
  logic [7:0]          hi_r, hi_nxt;
  logic [7:0]          crclo_r, crclo_nxt;
  logic                fin_r, fin_nxt;
  logic [2:0]          seq_r, seq_nxt;
  logic [AW-1:0]       ridx_r, ridx_nxt;
  logic [2:0]          fstat_r, fstat_nxt;
  logic [7:0]          fexc_r, fexc_nxt;

  logic        accept;
  logic        out_free;
  logic [2:0]  n_eff;
  logic [31:0] p_ext;
  logic [31:0] exp_len;
  logic [31:0] off;
  logic [31:0] ri;
  logic        frame_end;
  logic        crc_lo_pos;
  logic        hdr_bad;
  logic        crc_bad;
  logic        exc_hit;
  logic        rx_live;
  logic [7:0]  req_byte;
  logic        reg_last;

  assign in_stall  = (state_r != mbrm_pkg::S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // effective register count, saturated to 1..MAX_REGS
  always_comb begin
    if (cfg.register_count == 3'd0) begin
      n_eff = 3'd1;
    end else if (32'(cfg.register_count) > MAX_REGS) begin
      n_eff = 3'(MAX_REGS);
    end else begin
      n_eff = cfg.register_count;
    end
  end

  // frame position decode for the byte being processed
  assign rx_live    = !fin_r && (item_r.operation == mbrm_pkg::OP_RX);
  assign p_ext      = 32'(cnt_r);
  assign exp_len    = 32'd5 + {28'd0, n_eff, 1'b0};
  assign frame_end  = (p_ext + 32'd1) >= exp_len;
  assign crc_lo_pos = (p_ext + 32'd2) == exp_len;
  assign off        = p_ext - 32'd3;
  assign ri         = off >> 1;
  assign hdr_bad    = (faddr_r != cfg.slave_address) ||
                      (ffunc_r != mbrm_pkg::FUNC_READ_HOLD) ||
                      (flen_r != {4'd0, n_eff, 1'b0});
  assign crc_bad    = {item_r.rx_byte, crclo_r} != crc_r;
  assign exc_hit    = (p_ext == 32'd4) && (ffunc_r == mbrm_pkg::FUNC_EXCEPTION);
  assign reg_last   = (32'(ridx_r) + 32'd1) == 32'(n_eff);

  // request byte by position
  always_comb begin
    case (seq_r)
      3'd0:    req_byte = cfg.slave_address;
      3'd1:    req_byte = mbrm_pkg::FUNC_READ_HOLD;
      3'd2:    req_byte = cfg.start_register[15:8];
      3'd3:    req_byte = cfg.start_register[7:0];
      3'd4:    req_byte = 8'h00;
      3'd5:    req_byte = {5'd0, n_eff};
      3'd6:    req_byte = txcrc_r[7:0];
      default: req_byte = txcrc_r[15:8];
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mbrm_pkg::S_IDLE: begin
        if (accept) state_nxt = mbrm_pkg::S_EXEC;
      end
      mbrm_pkg::S_EXEC: begin
        state_nxt = mbrm_pkg::S_IDLE;
        if (item_r.operation == mbrm_pkg::OP_START) begin
          state_nxt = mbrm_pkg::S_REQ;
        end else if (!fin_r && item_r.operation == mbrm_pkg::OP_TIMEOUT) begin
          state_nxt = mbrm_pkg::S_FAIL;
        end else if (rx_live) begin
          if (frame_end) begin
            state_nxt = (hdr_bad || crc_bad) ? mbrm_pkg::S_FAIL : mbrm_pkg::S_RDREQ;
          end else if (exc_hit) begin
            state_nxt = mbrm_pkg::S_FAIL;
          end
        end
      end
      mbrm_pkg::S_REQ: begin
        if (out_free && seq_r == mbrm_pkg::REQ_LAST_IDX) state_nxt = mbrm_pkg::S_IDLE;
      end
      mbrm_pkg::S_FAIL: begin
        if (out_free) state_nxt = mbrm_pkg::S_IDLE;
      end
      mbrm_pkg::S_RDREQ: begin
        state_nxt = mbrm_pkg::S_REGS;
      end
      mbrm_pkg::S_REGS: begin
        if (out_free) state_nxt = reg_last ? mbrm_pkg::S_IDLE : mbrm_pkg::S_RDREQ;
      end
      default: state_nxt = mbrm_pkg::S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    item_nxt      = item_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    cnt_nxt       = cnt_r;
    crc_nxt       = crc_r;
    txcrc_nxt     = txcrc_r;
    faddr_nxt     = faddr_r;
    ffunc_nxt     = ffunc_r;
    flen_nxt      = flen_r;
    hi_nxt        = hi_r;
    crclo_nxt     = crclo_r;
    fin_nxt       = fin_r;
    seq_nxt       = seq_r;
    ridx_nxt      = ridx_r;
    fstat_nxt     = fstat_r;
    fexc_nxt      = fexc_r;
    mem_wr_en     = 1'b0;
    mem_wr_addr   = AW'(ri);
    mem_wr_data   = {hi_r, item_r.rx_byte};
    mem_rd_en     = 1'b0;
    mem_rd_addr   = ridx_r;

    unique case (state_r)
      mbrm_pkg::S_IDLE: begin
        if (accept) item_nxt = in_data;
      end
      mbrm_pkg::S_EXEC: begin
        if (item_r.operation == mbrm_pkg::OP_START) begin
          // abort anything in flight and start a new request
          cnt_nxt   = '0;
          crc_nxt   = mbrm_pkg::CRC_INIT;
          faddr_nxt = 8'h00;
          ffunc_nxt = 8'h00;
          flen_nxt  = 8'h00;
          hi_nxt    = 8'h00;
          crclo_nxt = 8'h00;
          fin_nxt   = 1'b0;
          seq_nxt   = 3'd0;
          txcrc_nxt = mbrm_pkg::CRC_INIT;
        end else if (!fin_r && item_r.operation == mbrm_pkg::OP_TIMEOUT) begin
          fstat_nxt = (cnt_r == '0) ? mbrm_pkg::ST_NO_RESP : mbrm_pkg::ST_INCOMPLETE;
          fexc_nxt  = 8'h00;
          fin_nxt   = 1'b1;
        end else if (rx_live) begin
          cnt_nxt = cnt_r + 1'b1;
          if (frame_end) begin
            // last byte is the CRC high byte: check header, then CRC
            fin_nxt   = 1'b1;
            fexc_nxt  = 8'h00;
            ridx_nxt  = '0;
            fstat_nxt = hdr_bad ? mbrm_pkg::ST_BAD_HEADER : mbrm_pkg::ST_CRC_ERROR;
          end else begin
            if (crc_lo_pos) begin
              crclo_nxt = item_r.rx_byte;
            end else begin
              crc_nxt = mbrm_pkg::crc_fold(crc_r, item_r.rx_byte);
              if (p_ext == 32'd0) begin
                faddr_nxt = item_r.rx_byte;
              end else if (p_ext == 32'd1) begin
                ffunc_nxt = item_r.rx_byte;
              end else if (p_ext == 32'd2) begin
                flen_nxt = item_r.rx_byte;
              end else if (!off[0]) begin
                hi_nxt = item_r.rx_byte;
              end else if (ri < 32'(MAX_REGS)) begin
                mem_wr_en = 1'b1;
              end
            end
            // exception reply reported on its fifth byte
            if (exc_hit) begin
              fstat_nxt = mbrm_pkg::ST_EXCEPTION;
              fexc_nxt  = flen_r;
              fin_nxt   = 1'b1;
            end
          end
        end
      end
      mbrm_pkg::S_REQ: begin
        if (out_free) begin
          out_valid_nxt               = 1'b1;
          out_data_nxt.kind           = mbrm_pkg::KIND_REQ;
          out_data_nxt.value          = {8'h00, req_byte};
          out_data_nxt.index          = {3'd0, seq_r};
          out_data_nxt.status         = mbrm_pkg::ST_OK;
          out_data_nxt.exception_code = 8'h00;
          out_data_nxt.last           = (seq_r == mbrm_pkg::REQ_LAST_IDX);
          if (seq_r < mbrm_pkg::REQ_CRC_LO_IDX) begin
            txcrc_nxt = mbrm_pkg::crc_fold(txcrc_r, req_byte);
          end
          seq_nxt = seq_r + 3'd1;
        end
      end
      mbrm_pkg::S_FAIL: begin
        if (out_free) begin
          out_valid_nxt               = 1'b1;
          out_data_nxt.kind           = mbrm_pkg::KIND_FAIL;
          out_data_nxt.value          = 16'h0000;
          out_data_nxt.index          = 6'd0;
          out_data_nxt.status         = fstat_r;
          out_data_nxt.exception_code = fexc_r;
          out_data_nxt.last           = 1'b1;
        end
      end
      mbrm_pkg::S_RDREQ: begin
        mem_rd_en = 1'b1;
      end
      mbrm_pkg::S_REGS: begin
        if (out_free) begin
          out_valid_nxt               = 1'b1;
          out_data_nxt.kind           = mbrm_pkg::KIND_REG;
          out_data_nxt.value          = mem_rd_data;
          out_data_nxt.index          = 6'(ridx_r);
          out_data_nxt.status         = mbrm_pkg::ST_OK;
          out_data_nxt.exception_code = 8'h00;
          out_data_nxt.last           = reg_last;
          ridx_nxt                    = ridx_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mbrm_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      crc_r       <= mbrm_pkg::CRC_INIT;
      faddr_r     <= 8'h00;
      ffunc_r     <= 8'h00;
      flen_r      <= 8'h00;
      hi_r        <= 8'h00;
      crclo_r     <= 8'h00;
      fin_r       <= 1'b1;
      seq_r       <= 3'd0;
      ridx_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      crc_r       <= crc_nxt;
      faddr_r     <= faddr_nxt;
      ffunc_r     <= ffunc_nxt;
      flen_r      <= flen_nxt;
      hi_r        <= hi_nxt;
      crclo_r     <= crclo_nxt;
      fin_r       <= fin_nxt;
      seq_r       <= seq_nxt;
      ridx_r      <= ridx_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    out_data_r <= out_data_nxt;
    txcrc_r    <= txcrc_nxt;
    fstat_r    <= fstat_nxt;
    fexc_r     <= fexc_nxt;
  end

endmodule
`default_nettype wire
